// File: design/hmtv_pkg.sv
// Package with the shared types, codes and character classifier of the height map validator.
package hmtv_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TOKEN   = 3'd1,
        ST_RAGGED  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_OVERRUN = 3'd4
    } t_hmtv_status;

    // Position inside the token grammar.
    typedef enum logic [2:0] {
        PH_GAP   = 3'd0,
        PH_MINUS = 3'd1,
        PH_DEC   = 3'd2,
        PH_COMMA = 3'd3,
        PH_ZERO  = 3'd4,
        PH_HEX   = 3'd5
    } t_hmtv_phase;

    // Character classes as seen by the grammar.
    typedef enum logic [3:0] {
        CL_NEWLINE = 4'd0,
        CL_SPACE   = 4'd1,
        CL_MINUS   = 4'd2,
        CL_COMMA   = 4'd3,
        CL_ZERO    = 4'd4,
        CL_DIGIT   = 4'd5,
        CL_LOWER_X = 4'd6,
        CL_HEX_LET = 4'd7,
        CL_OTHER   = 4'd8
    } t_hmtv_class;

    // One classified item, as it travels from the front to the back.
    typedef struct packed {
        t_hmtv_class cls;
        logic        has_char;
        logic        end_of_file;
    } t_hmtv_item;

    // Character constants.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Width of the result count fields.
    localparam int OUT_CNT_W = 12;

    // Maps one byte to its grammar class.
    function automatic t_hmtv_class hmtv_classify(input logic [7:0] c);
        t_hmtv_class cls;
        cls = CL_OTHER;
        if (c == CH_NEWLINE) begin
            cls = CL_NEWLINE;
        end else if (c == CH_SPACE) begin
            cls = CL_SPACE;
        end else if (c == CH_MINUS) begin
            cls = CL_MINUS;
        end else if (c == CH_COMMA) begin
            cls = CL_COMMA;
        end else if (c == CH_ZERO) begin
            cls = CL_ZERO;
        end else if (c > CH_ZERO && c <= CH_NINE) begin
            cls = CL_DIGIT;
        end else if (c == CH_LOWER_X) begin
            cls = CL_LOWER_X;
        end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
            cls = CL_HEX_LET;
        end
        return cls;
    endfunction

endpackage

// File: design/hmtv_in_if.sv
// Input channel interface: one byte of map text per transfer.
interface hmtv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_file;

    modport source (output valid, output char_code, output has_char, output end_of_file,
                    input ready);
    modport sink (input valid, input char_code, input has_char, input end_of_file,
                  output ready);
endinterface

// File: design/hmtv_out_if.sv
// Output channel interface: one validation result per transfer.
interface hmtv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] columns;
    logic [11:0] rows;

    modport source (output valid, output status, output columns, output rows, input ready);
    modport sink (input valid, input status, input columns, input rows, output ready);
endinterface

// File: design/hmtv_front.sv
// Front end: accepts input bytes, classifies them and pushes them into the queue.
module hmtv_front (
    hmtv_in_if.sink              i_byte,
    input  logic                 i_full,
    output logic                 o_push,
    output hmtv_pkg::t_hmtv_item o_item
);

    // Accept whenever the queue has room.
    assign i_byte.ready = !i_full;

    // An item with neither a byte nor an end mark does nothing, so it is dropped here.
    assign o_push = i_byte.valid && !i_full && (i_byte.has_char || i_byte.end_of_file);

    // Classify the byte for the back end.
    always_comb begin
        o_item.cls         = hmtv_pkg::hmtv_classify(i_byte.char_code);
        o_item.has_char    = i_byte.has_char;
        o_item.end_of_file = i_byte.end_of_file;
    end

endmodule

// File: design/hmtv_queue.sv
// Short FIFO of classified items between the front and the back.
module hmtv_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hmtv_pkg::t_hmtv_item i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output hmtv_pkg::t_hmtv_item o_item
);

    localparam int PTR_W = (hmtv_pkg::QUEUE_DEPTH > 1) ? $clog2(hmtv_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hmtv_pkg::QUEUE_DEPTH + 1);

    hmtv_pkg::t_hmtv_item r_mem [hmtv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic [PTR_W-1:0]     n_wr_ptr;
    logic [PTR_W-1:0]     n_rd_ptr;
    logic [CNT_W-1:0]     n_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_count == CNT_W'(hmtv_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and fill count update with wraparound at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(hmtv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(hmtv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/hmtv_back.sv
// Back end: token grammar, row and column counting, error tracking and the result register.
module hmtv_back #(
    parameter int MAX_COLS = 4095,
    parameter int MAX_ROWS = 4095
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hmtv_pkg::t_hmtv_item i_item,
    output logic                 o_pop,
    hmtv_out_if.source           o_result
);

    localparam int COL_BITS = $clog2(MAX_COLS + 1);
    localparam int ROW_BITS = $clog2(MAX_ROWS + 1);
    localparam int COL_W = (COL_BITS > hmtv_pkg::OUT_CNT_W) ? COL_BITS : hmtv_pkg::OUT_CNT_W;
    localparam int ROW_W = (ROW_BITS > hmtv_pkg::OUT_CNT_W) ? ROW_BITS : hmtv_pkg::OUT_CNT_W;

    hmtv_pkg::t_hmtv_phase  r_phase, n_phase;
    logic [COL_W-1:0]       r_tokens, n_tokens;
    logic [COL_W-1:0]       r_width, n_width;
    logic                   r_width_known, n_width_known;
    logic [ROW_W-1:0]       r_rows, n_rows;
    logic                   r_pending, n_pending;
    hmtv_pkg::t_hmtv_status r_err, n_err;
    logic                   r_out_valid, n_out_valid;
    hmtv_pkg::t_hmtv_status r_out_status;
    logic [11:0]            r_out_columns;
    logic [11:0]            r_out_rows;
    logic                   w_out_free;
    logic                   w_take;
    logic                   w_close;
    logic                   w_newline;

    // A result slot is free when empty or being drained in this cycle.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign o_pop      = i_valid && (!i_item.end_of_file || w_out_free);
    assign w_take     = o_pop;

    assign o_result.valid   = r_out_valid;
    assign o_result.status  = r_out_status;
    assign o_result.columns = r_out_columns;
    assign o_result.rows    = r_out_rows;

    // Grammar step, row close and end of stream for the item at the queue head.
    always_comb begin
        n_phase       = r_phase;
        n_tokens      = r_tokens;
        n_width       = r_width;
        n_width_known = r_width_known;
        n_rows        = r_rows;
        n_pending     = r_pending;
        n_err         = r_err;
        n_out_valid   = r_out_valid && !o_result.ready;
        w_newline     = 1'b0;
        w_close       = 1'b0;

        if (w_take) begin
            // Byte handling; bytes are ignored once an error is held.
            if (i_item.has_char && r_err == hmtv_pkg::ST_OK) begin
                if (i_item.cls == hmtv_pkg::CL_NEWLINE) begin
                    w_newline = 1'b1;
                end else if (i_item.cls == hmtv_pkg::CL_SPACE) begin
                    n_pending = 1'b1;
                    if (r_phase == hmtv_pkg::PH_COMMA || r_phase == hmtv_pkg::PH_ZERO) begin
                        n_err = hmtv_pkg::ST_TOKEN;
                    end
                    n_phase = hmtv_pkg::PH_GAP;
                end else begin
                    n_pending = 1'b1;
                    if (r_phase == hmtv_pkg::PH_GAP &&
                        r_tokens >= COL_W'(MAX_COLS)) begin
                        n_err = hmtv_pkg::ST_OVERRUN;
                    end else begin
                        if (r_phase == hmtv_pkg::PH_GAP) begin
                            n_tokens = r_tokens + COL_W'(1);
                        end
                        unique case (r_phase)
                            hmtv_pkg::PH_GAP, hmtv_pkg::PH_MINUS, hmtv_pkg::PH_DEC: begin
                                if (i_item.cls == hmtv_pkg::CL_MINUS &&
                                    r_phase == hmtv_pkg::PH_GAP) begin
                                    n_phase = hmtv_pkg::PH_MINUS;
                                end else if (i_item.cls == hmtv_pkg::CL_ZERO ||
                                             i_item.cls == hmtv_pkg::CL_DIGIT) begin
                                    n_phase = hmtv_pkg::PH_DEC;
                                end else if (i_item.cls == hmtv_pkg::CL_COMMA) begin
                                    n_phase = hmtv_pkg::PH_COMMA;
                                end else begin
                                    n_err = hmtv_pkg::ST_TOKEN;
                                end
                            end
                            hmtv_pkg::PH_COMMA: begin
                                if (i_item.cls == hmtv_pkg::CL_ZERO) begin
                                    n_phase = hmtv_pkg::PH_ZERO;
                                end else begin
                                    n_err = hmtv_pkg::ST_TOKEN;
                                end
                            end
                            hmtv_pkg::PH_ZERO: begin
                                if (i_item.cls == hmtv_pkg::CL_LOWER_X) begin
                                    n_phase = hmtv_pkg::PH_HEX;
                                end else begin
                                    n_err = hmtv_pkg::ST_TOKEN;
                                end
                            end
                            default: begin
                                if (!(i_item.cls == hmtv_pkg::CL_ZERO ||
                                      i_item.cls == hmtv_pkg::CL_DIGIT ||
                                      i_item.cls == hmtv_pkg::CL_HEX_LET)) begin
                                    n_err = hmtv_pkg::ST_TOKEN;
                                end
                            end
                        endcase
                    end
                end
            end

            // A newline closes the row; so does the end of a stream whose last row is open.
            w_close = w_newline ||
                      (i_item.end_of_file && n_err == hmtv_pkg::ST_OK && n_pending);

            if (w_close) begin
                if (n_phase == hmtv_pkg::PH_COMMA || n_phase == hmtv_pkg::PH_ZERO) begin
                    n_err = hmtv_pkg::ST_TOKEN;
                end
                n_phase = hmtv_pkg::PH_GAP;
                if (n_err == hmtv_pkg::ST_OK) begin
                    if (!n_width_known) begin
                        n_width       = n_tokens;
                        n_width_known = 1'b1;
                    end else if (n_tokens != n_width) begin
                        n_err = hmtv_pkg::ST_RAGGED;
                    end
                end
                if (n_err == hmtv_pkg::ST_OK) begin
                    if (n_rows >= ROW_W'(MAX_ROWS)) begin
                        n_err = hmtv_pkg::ST_OVERRUN;
                    end else begin
                        n_rows    = n_rows + ROW_W'(1);
                        n_tokens  = '0;
                        n_pending = 1'b0;
                    end
                end
            end

            // End of stream: report and return to the start state.
            if (i_item.end_of_file) begin
                if (n_err == hmtv_pkg::ST_OK && n_rows == '0) begin
                    n_err = hmtv_pkg::ST_EMPTY;
                end
                n_out_valid   = 1'b1;
                n_phase       = hmtv_pkg::PH_GAP;
                n_tokens      = '0;
                n_width_known = 1'b0;
                n_pending     = 1'b0;
            end
        end
    end

    // Control and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hmtv_pkg::PH_GAP;
            r_tokens      <= '0;
            r_width       <= '0;
            r_width_known <= 1'b0;
            r_rows        <= '0;
            r_pending     <= 1'b0;
            r_err         <= hmtv_pkg::ST_OK;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_tokens      <= n_tokens;
            r_width_known <= n_width_known;
            r_pending     <= n_pending;
            r_out_valid   <= n_out_valid;
            if (w_take && i_item.end_of_file) begin
                r_width <= '0;
                r_rows  <= '0;
                r_err   <= hmtv_pkg::ST_OK;
            end else begin
                r_width <= n_width;
                r_rows  <= n_rows;
                r_err   <= n_err;
            end
        end
    end

    // Result payload, loaded at the end of a stream.
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.end_of_file) begin
            r_out_status  <= n_err;
            r_out_columns <= n_width[11:0];
            r_out_rows    <= n_rows[11:0];
        end
    end

endmodule

// File: design/height_map_text_validator.sv
// Top level of the height map text validator: front end, queue and back end.
//
//  Channel    Dir  Payload                              Handshake
//  i_byte     in   char_code, has_char, end_of_file     valid / ready
//  o_result   out  status, columns, rows                valid / ready
//
// One byte is taken per cycle while the queue has room; a transfer is written into a
// two-entry queue, the back end consumes the queue head from there, and the result
// register is loaded when the back end takes the final item of a stream.
// The back end holds only on an end-of-stream item while the result register is full
// and not being drained; the input stalls once the queue holds two items.
// Reset is synchronous and active low and returns every counter to the start of a stream.
module height_map_text_validator #(
    parameter int MAX_COLS = 4095,
    parameter int MAX_ROWS = 4095
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmtv_in_if.sink    i_byte,
    hmtv_out_if.source o_result
);

    logic                 w_push;
    logic                 w_full;
    logic                 w_pop;
    logic                 w_q_valid;
    hmtv_pkg::t_hmtv_item w_push_item;
    hmtv_pkg::t_hmtv_item w_head_item;

    // Byte classification.
    hmtv_front u_front (
        .i_byte (i_byte),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    // Decoupling queue.
    hmtv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    // Grammar, counting and result.
    hmtv_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_head_item),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule

// File: test/tb_height_map_text_validator.sv
// Testbench for the height map text validator: directed and random byte streams, checked live.
`timescale 1ns / 1ps

module tb_height_map_text_validator;

    localparam int MAX_COLS       = 4095;
    localparam int MAX_ROWS       = 4095;
    localparam int CNT_W          = hmtv_pkg::OUT_CNT_W;
    localparam int PHASE_ITEMS    = 175;
    localparam int PHASE_STREAMS  = 10;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int STALL_LIMIT    = 2000;

    // How a stream is terminated when it is sent.
    typedef enum int {
        END_MARKER  = 0,
        END_ON_BYTE = 1,
        END_NONE    = 2
    } t_stream_end;

    // One validation result as the block should report it.
    typedef struct packed {
        hmtv_pkg::t_hmtv_status status;
        logic [CNT_W-1:0]       columns;
        logic [CNT_W-1:0]       rows;
    } t_map_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hmtv_in_if  byte_if ();
    hmtv_out_if result_if ();

    height_map_text_validator #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (result_if)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the validator.
    hmtv_pkg::t_hmtv_phase  tok_phase;
    int unsigned            row_tok_cnt;
    int unsigned            width_cols;
    bit                     width_seen;
    int unsigned            rows_done;
    bit                     row_started;
    hmtv_pkg::t_hmtv_status map_status;

    t_map_result  results_due[$];
    logic [7:0]   text_q[$];
    int unsigned  stim_items;
    int unsigned  mismatches;
    int unsigned  quiet_cycles = 0;
    int           src_idle_pct;
    int           sink_stall_pct;
    int unsigned  holdoff_left = 0;
    bit           holdoff_req  = 1'b0;
    bit           holdoff_ack  = 1'b0;

    function automatic void clear_map_state();
        tok_phase   = hmtv_pkg::PH_GAP;
        row_tok_cnt = 0;
        width_cols  = 0;
        width_seen  = 1'b0;
        rows_done   = 0;
        row_started = 1'b0;
        map_status  = hmtv_pkg::ST_OK;
    endfunction

    // Only the first error of a stream is kept.
    function automatic void note_error(input hmtv_pkg::t_hmtv_status code);
        if (map_status == hmtv_pkg::ST_OK) begin
            map_status = code;
        end
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= hmtv_pkg::CH_ZERO && c <= hmtv_pkg::CH_NINE;
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] c);
        return is_digit(c) ||
               (c >= hmtv_pkg::CH_LOWER_A && c <= hmtv_pkg::CH_LOWER_F) ||
               (c >= hmtv_pkg::CH_UPPER_A && c <= hmtv_pkg::CH_UPPER_F);
    endfunction

    // A token may not stop right after the comma or the zero of its hex prefix.
    function automatic void finish_token();
        if (tok_phase == hmtv_pkg::PH_COMMA || tok_phase == hmtv_pkg::PH_ZERO) begin
            note_error(hmtv_pkg::ST_TOKEN);
        end
        tok_phase = hmtv_pkg::PH_GAP;
    endfunction

    // Closing a row fixes the width on the first row and compares it afterwards.
    function automatic void close_map_row();
        finish_token();
        if (map_status != hmtv_pkg::ST_OK) begin
            return;
        end
        if (!width_seen) begin
            width_cols = row_tok_cnt;
            width_seen = 1'b1;
        end else if (row_tok_cnt != width_cols) begin
            note_error(hmtv_pkg::ST_RAGGED);
            return;
        end
        if (rows_done >= MAX_ROWS) begin
            note_error(hmtv_pkg::ST_OVERRUN);
            return;
        end
        rows_done++;
        row_tok_cnt = 0;
        row_started = 1'b0;
    endfunction

    // Token grammar for one byte of text.
    function automatic void take_map_char(input logic [7:0] c);
        if (c == hmtv_pkg::CH_NEWLINE) begin
            close_map_row();
            return;
        end
        row_started = 1'b1;
        if (c == hmtv_pkg::CH_SPACE) begin
            finish_token();
            return;
        end
        if (tok_phase == hmtv_pkg::PH_GAP) begin
            if (row_tok_cnt >= MAX_COLS) begin
                note_error(hmtv_pkg::ST_OVERRUN);
                return;
            end
            row_tok_cnt++;
        end
        case (tok_phase)
            hmtv_pkg::PH_GAP, hmtv_pkg::PH_MINUS, hmtv_pkg::PH_DEC: begin
                if (c == hmtv_pkg::CH_MINUS && tok_phase == hmtv_pkg::PH_GAP) begin
                    tok_phase = hmtv_pkg::PH_MINUS;
                end else if (is_digit(c)) begin
                    tok_phase = hmtv_pkg::PH_DEC;
                end else if (c == hmtv_pkg::CH_COMMA) begin
                    tok_phase = hmtv_pkg::PH_COMMA;
                end else begin
                    note_error(hmtv_pkg::ST_TOKEN);
                end
            end
            hmtv_pkg::PH_COMMA: begin
                if (c == hmtv_pkg::CH_ZERO) begin
                    tok_phase = hmtv_pkg::PH_ZERO;
                end else begin
                    note_error(hmtv_pkg::ST_TOKEN);
                end
            end
            hmtv_pkg::PH_ZERO: begin
                if (c == hmtv_pkg::CH_LOWER_X) begin
                    tok_phase = hmtv_pkg::PH_HEX;
                end else begin
                    note_error(hmtv_pkg::ST_TOKEN);
                end
            end
            default: begin
                if (!is_hex_digit(c)) begin
                    note_error(hmtv_pkg::ST_TOKEN);
                end
            end
        endcase
    endfunction

    // Applies one accepted item and queues the result that ends a stream.
    function automatic void predict_map_item(input logic [7:0] c, input logic has_char,
                                             input logic end_of_file);
        if (has_char && map_status == hmtv_pkg::ST_OK) begin
            take_map_char(c);
        end
        if (end_of_file) begin
            if (map_status == hmtv_pkg::ST_OK && row_started) begin
                close_map_row();
            end
            if (map_status == hmtv_pkg::ST_OK && rows_done == 0) begin
                note_error(hmtv_pkg::ST_EMPTY);
            end
            results_due.push_back('{map_status, CNT_W'(width_cols), CNT_W'(rows_done)});
            clear_map_state();
        end
    endfunction

    // Every input transfer feeds the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            predict_map_item(byte_if.char_code, byte_if.has_char, byte_if.end_of_file);
        end
    end

    // Every result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_map_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result: status %0d columns %0d rows %0d",
                       result_if.status, result_if.columns, result_if.rows);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (result_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, result_if.status);
                    mismatches++;
                end
                if (result_if.columns !== want.columns) begin
                    $error("columns: expected %0d, actual %0d", want.columns,
                           result_if.columns);
                    mismatches++;
                end
                if (result_if.rows !== want.rows) begin
                    $error("rows: expected %0d, actual %0d", want.rows, result_if.rows);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (holdoff_req != holdoff_ack) begin
            holdoff_ack       <= holdoff_req;
            holdoff_left      <= HOLDOFF_CYCLES;
            result_if.ready   <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left      <= holdoff_left - 1;
            result_if.ready   <= 1'b0;
        end else begin
            result_if.ready   <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_height_map_text_validator NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item and returns at the edge where it is transferred; valid stays high.
    task automatic send_item(input logic [7:0] c, input logic has_char, input logic eof);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.char_code   <= c;
        byte_if.has_char    <= has_char;
        byte_if.end_of_file <= eof;
        @(posedge i_clk);
        while (!byte_if.ready) begin
            @(posedge i_clk);
        end
        if (has_char || eof) begin
            stim_items++;
        end
    endtask

    // Sends the text buffer as one stream, with empty items mixed in at gap_pct.
    task automatic send_text(input t_stream_end end_mode, input int gap_pct);
        bit eof_here;
        foreach (text_q[k]) begin
            if ($urandom_range(99) < gap_pct) begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            eof_here = (end_mode == END_ON_BYTE) && (k == text_q.size() - 1);
            send_item(text_q[k], 1'b1, eof_here);
        end
        if (end_mode == END_MARKER || (end_mode == END_ON_BYTE && text_q.size() == 0)) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int k = 0; k < s.len(); k++) begin
            text_q.push_back(s[k]);
        end
    endtask

    // Lowers valid and waits until every predicted result has been transferred.
    task automatic wait_results_done();
        byte_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (results_due.size() != 0);
    endtask

    // Random token: optional minus, digits, optional hex part, now and then a cut prefix.
    task automatic add_token();
        bit neg;
        bit hex_part;
        int n_dig;
        int cut;
        neg      = ($urandom_range(3) == 0);
        n_dig    = $urandom_range(2);
        hex_part = ($urandom_range(2) == 0);
        if (!neg && n_dig == 0 && !hex_part) begin
            n_dig = 1;
        end
        if (neg) begin
            text_q.push_back(hmtv_pkg::CH_MINUS);
        end
        repeat (n_dig) text_q.push_back(8'(hmtv_pkg::CH_ZERO + $urandom_range(9)));
        if (hex_part) begin
            cut = $urandom_range(19);
            text_q.push_back(hmtv_pkg::CH_COMMA);
            if (cut != 0) begin
                text_q.push_back(hmtv_pkg::CH_ZERO);
            end
            if (cut > 1) begin
                text_q.push_back(hmtv_pkg::CH_LOWER_X);
                repeat ($urandom_range(2)) begin
                    case ($urandom_range(2))
                        0: text_q.push_back(8'(hmtv_pkg::CH_ZERO + $urandom_range(9)));
                        1: text_q.push_back(8'(hmtv_pkg::CH_LOWER_A + $urandom_range(5)));
                        default: text_q.push_back(8'(hmtv_pkg::CH_UPPER_A + $urandom_range(5)));
                    endcase
                end
            end
        end
    endtask

    // One row of tokens with single or double spaces, sometimes padded at either end.
    task automatic add_row(input int n_tok, input bit with_newline);
        if ($urandom_range(9) == 0) begin
            text_q.push_back(hmtv_pkg::CH_SPACE);
        end
        for (int t = 0; t < n_tok; t++) begin
            if (t > 0) begin
                repeat ($urandom_range(1, 2)) text_q.push_back(hmtv_pkg::CH_SPACE);
            end
            add_token();
        end
        if ($urandom_range(9) == 0) begin
            text_q.push_back(hmtv_pkg::CH_SPACE);
        end
        if (with_newline) begin
            text_q.push_back(hmtv_pkg::CH_NEWLINE);
        end
    endtask

    // Mostly well-formed small maps; some get a ragged row, a stray byte, or are pure noise.
    task automatic build_random_stream();
        int n_rows;
        int n_cols;
        int row_cols;
        text_q.delete();
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
            return;
        end
        n_rows = $urandom_range(1, 3);
        n_cols = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
        for (int r = 0; r < n_rows; r++) begin
            row_cols = n_cols;
            if ($urandom_range(11) == 0) begin
                row_cols = (n_cols > 0 && $urandom_range(1) != 0) ? n_cols - 1 : n_cols + 1;
            end
            add_row(row_cols, (r < n_rows - 1) || ($urandom_range(3) != 0));
        end
        if (text_q.size() > 0 && $urandom_range(4) == 0) begin
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    task automatic test_empty_input();
        text_q.delete();
        send_text(END_MARKER, 0);
        load_text("\n");
        send_text(END_MARKER, 0);
    endtask

    // Every grammar element, an empty item mid-stream, and a last row ended by its byte.
    task automatic test_token_grammar();
        load_text("-9,0xaF 0\n");
        send_text(END_NONE, 0);
        send_item(8'hFF, 1'b0, 1'b0);
        load_text("- ,0x");
        send_text(END_ON_BYTE, 0);
    endtask

    task automatic test_ragged_row();
        load_text("1\n1 2");
        send_text(END_ON_BYTE, 0);
    endtask

    // A NUL byte fails the stream; later bytes, even bad ones, change nothing.
    task automatic test_sticky_error();
        load_text("1\n");
        text_q.push_back(8'h00);
        text_q.push_back(hmtv_pkg::CH_COMMA);
        text_q.push_back(hmtv_pkg::CH_NEWLINE);
        text_q.push_back(8'hFF);
        send_text(END_ON_BYTE, 0);
    endtask

    task automatic test_cut_prefix();
        load_text(",0");
        send_text(END_ON_BYTE, 0);
        load_text("7 ,\n");
        send_text(END_MARKER, 0);
    endtask

    // The receiver holds off while one-byte streams keep coming, so the input backs up.
    task automatic test_result_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holdoff_req    = !holdoff_req;
        repeat (12) begin
            text_q.delete();
            text_q.push_back(8'(hmtv_pkg::CH_ZERO + $urandom_range(9)));
            send_text(END_ON_BYTE, 0);
        end
        wait_results_done();
    endtask

    task automatic test_random_streams(input int idle_pct, input int stall_pct);
        int unsigned first_item;
        int n_streams;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        first_item     = stim_items;
        n_streams      = 0;
        while (stim_items - first_item < PHASE_ITEMS || n_streams < PHASE_STREAMS) begin
            build_random_stream();
            send_text(t_stream_end'($urandom_range(1)), 10);
            n_streams++;
        end
        wait_results_done();
    endtask

    initial begin
        byte_if.valid       <= 1'b0;
        byte_if.char_code   <= 8'h00;
        byte_if.has_char    <= 1'b0;
        byte_if.end_of_file <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        stim_items     = 0;
        mismatches     = 0;
        clear_map_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_input();
        test_token_grammar();
        test_ragged_row();
        test_sticky_error();
        test_cut_prefix();
        wait_results_done();
        test_result_backpressure();
        test_random_streams(0, 0);
        test_random_streams(64, 0);
        test_random_streams(0, 64);
        test_random_streams(12, 12);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d predicted results never arrived", results_due.size());
        end
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("tb_height_map_text_validator OK");
        end else begin
            $display("tb_height_map_text_validator NOT OK");
        end
        $finish;
    end

endmodule

// File: height_map_text_validator.f
design/hmtv_pkg.sv
design/hmtv_in_if.sv
design/hmtv_out_if.sv
design/hmtv_front.sv
design/hmtv_queue.sv
design/hmtv_back.sv
design/height_map_text_validator.sv
test/tb_height_map_text_validator.sv
